@@ src/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants for the tar stream reader.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int OFF_W         = $clog2(BLOCK_BYTES);
    localparam int SIZE_BITS_DEF = 36;
    localparam int FS_W          = 36;
    localparam int Q_DEPTH       = 2;

    localparam logic [OFF_W-1:0] NAME_END_OFF = OFF_W'(99);
    localparam logic [OFF_W-1:0] SIZE_OFF     = OFF_W'(124);
    localparam logic [OFF_W-1:0] SIZE_LEN     = OFF_W'(12);
    localparam logic [OFF_W-1:0] MAGIC_OFF    = OFF_W'(257);
    localparam logic [OFF_W-1:0] MAGIC_LEN    = OFF_W'(5);
    localparam logic [OFF_W-1:0] LAST_OFF     = OFF_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;

    typedef enum logic [2:0] {
        K_PAD     = 3'd0,
        K_HDR     = 3'd1,
        K_HDR_OK  = 3'd2,
        K_DATA    = 3'd3,
        K_END     = 3'd4,
        K_ERR     = 3'd5,
        K_IGNORED = 3'd6
    } kind_t;

    // One classified item, front to back.
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data;
        logic              name_end;
        logic [FS_W-1:0]   size;
        logic              last;
    } rec_t;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;  // u
            3'd1:    c = 8'h73;  // s
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ src/tsr_front.sv @@
// ----------------------------------------------------------------------------
// tsr_front
// Accepts archive bytes, tracks block position and phase, checks the header
// and parses the size field. Emits one classified record per byte.
// ----------------------------------------------------------------------------
module tsr_front
    import tsr_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       q_full,
    output logic       q_wr,
    output rec_t       q_rec
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_ENDED,
        PH_ERROR
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFF_W-1:0]       block_off_reg, block_off_next;
    logic [OFF_W-1:0]       hdr_cnt_reg, hdr_cnt_next;
    logic [SIZE_BITS-1:0]   remain_reg, remain_next;
    logic [SIZE_BITS-1:0]   accum_reg, accum_next;
    logic                   size_ended_reg, size_ended_next;
    logic                   size_bad_reg, size_bad_next;
    logic                   magic_ok_reg, magic_ok_next;
    logic                   nonzero_reg, nonzero_next;

    logic                   take;
    logic                   nonzero_now;
    logic                   in_magic;
    logic                   in_size;
    logic [SIZE_BITS-1:0]   remain_dec;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;
    assign q_wr     = take;

    assign nonzero_now = nonzero_reg || (byte_in != CH_NUL);
    assign in_magic    = (hdr_cnt_reg >= MAGIC_OFF) && (hdr_cnt_reg < MAGIC_OFF + MAGIC_LEN);
    assign in_size     = (hdr_cnt_reg >= SIZE_OFF) && (hdr_cnt_reg < SIZE_OFF + SIZE_LEN);
    assign remain_dec  = remain_reg - SIZE_BITS'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        block_off_next  = block_off_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        remain_next     = remain_reg;
        accum_next      = accum_reg;
        size_ended_next = size_ended_reg;
        size_bad_next   = size_bad_reg;
        magic_ok_next   = magic_ok_reg;
        nonzero_next    = nonzero_reg;

        q_rec.kind     = K_IGNORED;
        q_rec.data     = byte_in;
        q_rec.name_end = 1'b0;
        q_rec.size     = FS_W'(accum_reg);
        q_rec.last     = 1'b0;

        unique case (phase_reg)
            PH_ENDED, PH_ERROR:
            begin
                q_rec.kind = K_IGNORED;
            end
            PH_DATA:
            begin
                block_off_next = block_off_reg + OFF_W'(1);
                remain_next    = remain_dec;
                q_rec.kind     = K_DATA;
                q_rec.last     = (remain_dec == '0);
                if (remain_dec == '0)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                block_off_next = block_off_reg + OFF_W'(1);
                if (hdr_cnt_reg == '0 && block_off_reg != '0)
                begin
                    q_rec.kind = K_PAD;
                end
                else
                begin
                    nonzero_next   = nonzero_now;
                    q_rec.name_end = (hdr_cnt_reg == NAME_END_OFF);
                    if (in_magic &&
                        byte_in != magic_char(3'(hdr_cnt_reg - MAGIC_OFF)))
                    begin
                        magic_ok_next = 1'b0;
                    end
                    if (in_size && !size_ended_reg)
                    begin
                        priority if (byte_in == CH_NUL || byte_in == CH_SPACE)
                        begin
                            size_ended_next = 1'b1;
                        end
                        else if (byte_in < CH_0 || byte_in > CH_7)
                        begin
                            size_bad_next = 1'b1;
                        end
                        else
                        begin
                            if (accum_reg[SIZE_BITS-1 -: 3] != 3'b000)
                            begin
                                size_bad_next = 1'b1;
                            end
                            accum_next = {accum_reg[SIZE_BITS-4:0], byte_in[2:0]};
                        end
                    end

                    if (hdr_cnt_reg != LAST_OFF)
                    begin
                        hdr_cnt_next = hdr_cnt_reg + OFF_W'(1);
                        q_rec.kind   = K_HDR;
                    end
                    else
                    begin
                        // header complete: verdict, then reset the header state
                        priority if (!magic_ok_reg)
                        begin
                            q_rec.kind = nonzero_now ? K_ERR : K_END;
                            phase_next = nonzero_now ? PH_ERROR : PH_ENDED;
                        end
                        else if (size_bad_reg)
                        begin
                            q_rec.kind = K_ERR;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            q_rec.kind  = K_HDR_OK;
                            remain_next = accum_reg;
                            phase_next  = (accum_reg != '0) ? PH_DATA : PH_HEADER;
                        end
                        hdr_cnt_next    = '0;
                        accum_next      = '0;
                        size_ended_next = 1'b0;
                        size_bad_next   = 1'b0;
                        magic_ok_next   = 1'b1;
                        nonzero_next    = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            block_off_reg  <= '0;
            hdr_cnt_reg    <= '0;
            remain_reg     <= '0;
            accum_reg      <= '0;
            size_ended_reg <= 1'b0;
            size_bad_reg   <= 1'b0;
            magic_ok_reg   <= 1'b1;
            nonzero_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            block_off_reg  <= block_off_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            remain_reg     <= remain_next;
            accum_reg      <= accum_next;
            size_ended_reg <= size_ended_next;
            size_bad_reg   <= size_bad_next;
            magic_ok_reg   <= magic_ok_next;
            nonzero_reg    <= nonzero_next;
        end
    end

endmodule

@@ src/tsr_queue.sv @@
// ----------------------------------------------------------------------------
// tsr_queue
// Short queue of classified records between front and back.
// ----------------------------------------------------------------------------
module tsr_queue
    import tsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  rec_t wr_rec,
    output logic full,
    input  logic rd,
    output logic rd_valid,
    output rec_t rd_rec
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    rec_t            mem_reg [Q_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign full     = (count_reg == CW'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

@@ src/tsr_back.sv @@
// ----------------------------------------------------------------------------
// tsr_back
// Turns queued records into result items and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
module tsr_back
    import tsr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  rec_t            q_rec,
    output logic            q_rd,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      byte_out,
    output logic [FS_W-1:0] file_size,
    output logic            last_of_file
);

    logic            valid_reg;
    kind_t           kind_reg;
    logic [7:0]      byte_reg;
    logic [FS_W-1:0] size_reg;
    logic            last_reg;
    logic            load;
    logic            pass_byte;

    assign load = q_valid && (!valid_reg || !out_stall);
    assign q_rd = load;

    // only header and data bytes carry a byte; the name terminator reads zero
    assign pass_byte = (q_rec.kind == K_HDR || q_rec.kind == K_HDR_OK ||
                        q_rec.kind == K_DATA) && !q_rec.name_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= q_rec.kind;
            byte_reg <= pass_byte ? q_rec.data : 8'h00;
            size_reg <= (q_rec.kind == K_HDR_OK) ? q_rec.size : '0;
            last_reg <= (q_rec.kind == K_DATA) && q_rec.last;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign byte_out     = byte_reg;
    assign file_size    = size_reg;
    assign last_of_file = last_reg;

endmodule

@@ src/tar_stream_reader_top.sv @@
// ----------------------------------------------------------------------------
// tar_stream_reader_top
// Byte-serial ustar archive reader: padding skip, header check, data pass.
// ----------------------------------------------------------------------------
// Takes one archive byte per cycle and returns exactly one result item per
// byte. The front end classifies each byte in the cycle it is accepted and
// writes a record into a two-entry queue; the back end formats it into the
// output register, which drives the result onto the outputs. in_stall rises
// only when the queue is full, which happens only while out_stall holds
// results back; with out_stall low the block sustains one byte per clock.
// The size field is SIZE_BITS wide internally and file_size shows its low
// 36 bits. End of archive and errors are sticky until reset; after them
// every byte returns an ignored item.
// ----------------------------------------------------------------------------
module tar_stream_reader_top
    import tsr_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      byte_in,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      byte_out,
    output logic [FS_W-1:0] file_size,
    output logic            last_of_file
);

    logic q_full;
    logic q_wr;
    rec_t q_wr_rec;
    logic q_rd;
    logic q_valid;
    rec_t q_rd_rec;

    tsr_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .byte_in  (byte_in),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_rec    (q_wr_rec)
    );

    tsr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_rec   (q_wr_rec),
        .full     (q_full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_rec   (q_rd_rec)
    );

    tsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_rec        (q_rd_rec),
        .q_rd         (q_rd),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .byte_out     (byte_out),
        .file_size    (file_size),
        .last_of_file (last_of_file)
    );

endmodule

@@ src/tsr_checker.sv @@
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks on the tar stream reader's result items.
// ----------------------------------------------------------------------------
module tsr_checker
    import tsr_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_stall,
    input logic [2:0]      kind,
    input logic [7:0]      byte_out,
    input logic [FS_W-1:0] file_size,
    input logic            last_of_file
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(byte_out) &&
            $stable(file_size) && $stable(last_of_file))
        else $error("result item changed while stalled");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_file |-> kind == K_DATA)
        else $error("last_of_file on a non-data item");

    a_size_only_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != K_HDR_OK |-> file_size == '0)
        else $error("file_size set outside an accepted header");

    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_PAD || kind == K_END || kind == K_ERR ||
            kind == K_IGNORED) |-> byte_out == 8'h00)
        else $error("byte_out set on an item that carries no byte");

endmodule

bind tar_stream_reader_top tsr_checker u_tsr_checker (.*);
